@@ hdl/wufh_pkg.sv @@
// Package for the weighted union-find core: widths, sequencer codes and the microcode table.
package wufh_pkg;

  localparam int NODE_COUNT_DEF = 1024;
  localparam int NODE_W         = 10;
  localparam int SIZE_W         = 11;

  typedef enum logic [3:0] {
    ST_CLR   = 4'd0,
    ST_IDLE  = 4'd1,
    ST_FRD   = 4'd2,
    ST_FCHK  = 4'd3,
    ST_FHOP  = 4'd4,
    ST_FDONE = 4'd5,
    ST_WAIT  = 4'd6,
    ST_SRA   = 4'd7,
    ST_SRB   = 4'd8,
    ST_CMP   = 4'd9
  } step_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_ACCEPT,
    COND_BAD,
    COND_AT_ROOT,
    COND_FIRST_FIND,
    COND_OUT_BUSY,
    COND_CLR_MORE
  } cond_t;

  typedef struct packed {
    logic  in_rdy;       // accept a transaction in this step
    logic  p_addr_data;  // parent read address from read data, else from cur
    logic  s_addr_rb;    // size read address rb, else ra
    logic  hop_we;       // halving write, cur follows grandparent
    logic  finish_find;  // shift root into ra/rb, load second node
    logic  sa_load;
    logic  commit;       // union writes and result load
    logic  clear_we;
    cond_t cond;
    step_t target;
  } ctrl_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c = '0;
    unique case (s)
      ST_CLR: begin
        c.clear_we = 1'b1;
        c.cond     = COND_CLR_MORE;
        c.target   = ST_CLR;
      end
      ST_IDLE: begin
        c.in_rdy = 1'b1;
        c.cond   = COND_NO_ACCEPT;
        c.target = ST_IDLE;
      end
      ST_FRD: begin
        c.cond   = COND_BAD;
        c.target = ST_WAIT;
      end
      ST_FCHK: begin
        c.p_addr_data = 1'b1;
        c.cond        = COND_AT_ROOT;
        c.target      = ST_FDONE;
      end
      ST_FHOP: begin
        c.p_addr_data = 1'b1;
        c.hop_we      = 1'b1;
        c.cond        = COND_ALWAYS;
        c.target      = ST_FCHK;
      end
      ST_FDONE: begin
        c.finish_find = 1'b1;
        c.cond        = COND_FIRST_FIND;
        c.target      = ST_FRD;
      end
      ST_WAIT: begin
        c.cond   = COND_OUT_BUSY;
        c.target = ST_WAIT;
      end
      ST_SRA: begin
        c.cond   = COND_NEXT;
        c.target = ST_SRB;
      end
      ST_SRB: begin
        c.s_addr_rb = 1'b1;
        c.sa_load   = 1'b1;
        c.cond      = COND_NEXT;
        c.target    = ST_CMP;
      end
      ST_CMP: begin
        c.commit = 1'b1;
        c.cond   = COND_ALWAYS;
        c.target = ST_IDLE;
      end
      default: begin
        c.cond   = COND_ALWAYS;
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

@@ hdl/wufh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module wufh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/weighted_union_find_halving_core.sv @@
// Top level: weighted quick-union with path halving, run by a microcoded sequencer.
// After reset the core sweeps both tables, one node per cycle, before in_ready first
// rises. Each transaction finds the root of first_node, then of second_node, repointing
// every visited node to its grandparent, and then links the smaller tree under the
// larger (ties under the first root). The parent table has one read and one write port,
// so each parent hop of a find takes a check step and a halving-write step. When
// both finds are done, the core waits while an earlier result is still unaccepted.
// in_ready rises again the cycle after the result is loaded. A pair with an index at or
// above NODE_COUNT leaves the tables alone and returns all zeros.
// The result sits in an output register; the next pair is accepted while it waits.
module weighted_union_find_halving_core #(
  parameter int NODE_COUNT = wufh_pkg::NODE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [wufh_pkg::NODE_W-1:0] first_node,
  input  logic [wufh_pkg::NODE_W-1:0] second_node,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        merged,
  output logic [wufh_pkg::NODE_W-1:0] root_node,
  output logic [wufh_pkg::SIZE_W-1:0] set_size
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int SW = $clog2(NODE_COUNT + 1);
  localparam logic [NW-1:0] LAST_NODE = NW'(NODE_COUNT - 1);

  wufh_pkg::step_t step, step_next;
  wufh_pkg::ctrl_t ctrl;

  logic [NW-1:0] cur, node_b, ra, rb, clr_idx;
  logic [SW-1:0] sa;
  logic          phase, bad;
  logic          accept, bad_in, take;

  logic          p_we, s_we;
  logic [NW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
  logic [NW-1:0] s_waddr, s_raddr;
  logic [SW-1:0] s_wdata, s_rdata, sum;
  logic          same_root, a_smaller;

  always_comb begin
    ctrl = wufh_pkg::ucode(step);
  end

  assign in_ready = ctrl.in_rdy;
  assign accept   = in_valid && in_ready;
  assign bad_in   = (32'(first_node) >= 32'(NODE_COUNT)) ||
                    (32'(second_node) >= 32'(NODE_COUNT));

  always_comb begin
    case (ctrl.cond)
      wufh_pkg::COND_NEXT:       take = 1'b0;
      wufh_pkg::COND_ALWAYS:     take = 1'b1;
      wufh_pkg::COND_NO_ACCEPT:  take = !accept;
      wufh_pkg::COND_BAD:        take = bad;
      wufh_pkg::COND_AT_ROOT:    take = (p_rdata == cur);
      wufh_pkg::COND_FIRST_FIND: take = !phase;
      wufh_pkg::COND_OUT_BUSY:   take = out_valid && !out_ready;
      wufh_pkg::COND_CLR_MORE:   take = (clr_idx != LAST_NODE);
      default:                   take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      step_next = ctrl.target;
    end else begin
      step_next = wufh_pkg::step_t'(step + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= wufh_pkg::ST_CLR;
    end else begin
      step <= step_next;
    end
  end

  // datapath
  assign same_root = (ra == rb);
  assign a_smaller = (sa < s_rdata);
  assign sum       = sa + s_rdata;

  assign p_raddr = ctrl.p_addr_data ? p_rdata : cur;
  assign s_raddr = ctrl.s_addr_rb ? rb : ra;

  always_comb begin
    p_we    = 1'b0;
    p_waddr = cur;
    p_wdata = p_rdata;
    s_we    = 1'b0;
    s_waddr = ra;
    s_wdata = sum;
    if (ctrl.clear_we) begin
      p_we    = 1'b1;
      p_waddr = clr_idx;
      p_wdata = clr_idx;
      s_we    = 1'b1;
      s_waddr = clr_idx;
      s_wdata = SW'(1);
    end else if (ctrl.hop_we) begin
      p_we = 1'b1;
    end else if (ctrl.commit && !bad && !same_root) begin
      p_we    = 1'b1;
      s_we    = 1'b1;
      p_waddr = a_smaller ? ra : rb;
      p_wdata = a_smaller ? rb : ra;
      s_waddr = a_smaller ? rb : ra;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      phase   <= 1'b0;
    end else begin
      if (ctrl.clear_we) begin
        clr_idx <= clr_idx + NW'(1);
      end
      if (ctrl.finish_find) begin
        phase <= !phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur    <= NW'(first_node);
      node_b <= NW'(second_node);
      bad    <= bad_in;
    end else if (ctrl.hop_we) begin
      cur <= p_rdata;
    end else if (ctrl.finish_find) begin
      cur <= node_b;
      ra  <= rb;
      rb  <= cur;
    end
    if (ctrl.sa_load) begin
      sa <= s_rdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      if (bad) begin
        merged    <= 1'b0;
        root_node <= '0;
        set_size  <= '0;
      end else if (same_root) begin
        merged    <= 1'b0;
        root_node <= wufh_pkg::NODE_W'(ra);
        set_size  <= wufh_pkg::SIZE_W'(sa);
      end else begin
        merged    <= 1'b1;
        root_node <= wufh_pkg::NODE_W'(a_smaller ? rb : ra);
        set_size  <= wufh_pkg::SIZE_W'(sum);
      end
    end
  end

  wufh_ram #(
    .WIDTH(NW),
    .DEPTH(NODE_COUNT)
  ) u_parent (
    .clk  (clk),
    .we   (p_we),
    .waddr(p_waddr),
    .wdata(p_wdata),
    .raddr(p_raddr),
    .rdata(p_rdata)
  );

  wufh_ram #(
    .WIDTH(SW),
    .DEPTH(NODE_COUNT)
  ) u_size (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  // checks
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |-> !out_valid)
    else $error("result overwritten before delivery");

  a_rose_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step == wufh_pkg::ST_CMP))
    else $error("result raised outside commit step");

  a_hop_no_self: assert property (@(posedge clk) disable iff (rst)
    ctrl.hop_we |-> (p_rdata != cur))
    else $error("halving write would make a node its own parent");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear_we |-> !in_ready)
    else $error("input taken during table clear");

endmodule

@@ bench/set_merge_monitor.sv @@
// Channel monitor for the union-find core: predicts each pair's merge result and checks it.
module set_merge_monitor
  import wufh_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [NODE_W-1:0] first_node,
  input  logic [NODE_W-1:0] second_node,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              merged,
  input  logic [NODE_W-1:0] root_node,
  input  logic [SIZE_W-1:0] set_size,
  output int                failures,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              merged;
    logic [NODE_W-1:0] root;
    logic [SIZE_W-1:0] members;
  } merge_result_t;

  logic [NODE_W-1:0] link_of[NODE_COUNT];
  logic [SIZE_W-1:0] members_of[NODE_COUNT];
  merge_result_t     pending_merges[$];

  // walk to the root, repointing each visited node to its grandparent
  function automatic logic [NODE_W-1:0] climb_to_root(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] cur;
    int                hops;
    cur  = node;
    hops = 0;
    while (link_of[cur] != cur && hops < NODE_COUNT) begin
      link_of[cur] = link_of[link_of[cur]];
      cur          = link_of[cur];
      hops++;
    end
    return cur;
  endfunction

  function automatic merge_result_t predict_merge(input logic [NODE_W-1:0] a,
                                                  input logic [NODE_W-1:0] b);
    merge_result_t     r;
    logic [NODE_W-1:0] ra;
    logic [NODE_W-1:0] rb;
    r = '0;
    if (int'(a) >= NODE_COUNT || int'(b) >= NODE_COUNT) return r;
    ra = climb_to_root(a);
    rb = climb_to_root(b);
    if (ra == rb) begin
      r.root = ra;
    end else if (members_of[ra] < members_of[rb]) begin
      link_of[ra]    = rb;
      members_of[rb] = members_of[rb] + members_of[ra];
      r.root         = rb;
      r.merged       = 1'b1;
    end else begin
      link_of[rb]    = ra;
      members_of[ra] = members_of[ra] + members_of[rb];
      r.root         = ra;
      r.merged       = 1'b1;
    end
    r.members = members_of[r.root];
    return r;
  endfunction

  always @(posedge clk) begin
    merge_result_t want;
    if (rst) begin
      for (int k = 0; k < NODE_COUNT; k++) begin
        link_of[k]    = NODE_W'(k);
        members_of[k] = SIZE_W'(1);
      end
      pending_merges.delete();
      failures    = 0;
      outstanding = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_merges.size() == 0) begin
          if (failures < 10)
            $display("unexpected transaction: merged=%0d root=%0d size=%0d",
                     merged, root_node, set_size);
          failures++;
        end else begin
          want = pending_merges.pop_front();
          if (merged !== want.merged || root_node !== want.root ||
              set_size !== want.members) begin
            if (failures < 10)
              $display("mismatch: expected merged=%0d root=%0d size=%0d, got %0d %0d %0d",
                       want.merged, want.root, want.members, merged, root_node, set_size);
            failures++;
          end
        end
      end
      if (in_valid && in_ready) pending_merges.push_back(predict_merge(first_node, second_node));
      outstanding = pending_merges.size();
    end
  end

endmodule

@@ bench/weighted_union_find_halving_core_test.sv @@
// Testbench top for the union-find core: clock, reset, pair stimulus and verdict.
module weighted_union_find_halving_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wufh_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PAIRS = 1100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [NODE_W-1:0] first_node = '0;
  logic [NODE_W-1:0] second_node = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              merged;
  logic [NODE_W-1:0] root_node;
  logic [SIZE_W-1:0] set_size;
  int                failures;
  int                outstanding;
  int                cycles = 0;
  bit                calm = 1'b0;

  weighted_union_find_halving_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_node(first_node), .second_node(second_node),
    .out_valid(out_valid), .out_ready(out_ready),
    .merged(merged), .root_node(root_node), .set_size(set_size)
  );

  set_merge_monitor monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_node(first_node), .second_node(second_node),
    .out_valid(out_valid), .out_ready(out_ready),
    .merged(merged), .root_node(root_node), .set_size(set_size),
    .failures(failures), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_pair(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    first_node  <= a;
    second_node <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int                base;
    int                pick;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ties, smaller-under-larger, repeats and extremes
    send_pair(10'd0, 10'd0);
    send_pair(10'd0, 10'd1);
    send_pair(10'd1, 10'd0);
    send_pair(10'd1023, 10'd1022);
    send_pair(10'd1022, 10'd1023);
    send_pair(10'd2, 10'd0);
    send_pair(10'd1023, 10'd0);
    send_pair(10'd1022, 10'd2);
    send_pair(10'd3, 10'd4);
    send_pair(10'd5, 10'd6);
    send_pair(10'd3, 10'd5);
    send_pair(10'd7, 10'd8);
    send_pair(10'd9, 10'd10);
    send_pair(10'd7, 10'd9);
    send_pair(10'd3, 10'd7);
    send_pair(10'd0, 10'd3);
    send_pair(10'd1022, 10'd10);
    send_pair(10'h2AA, 10'h155);
    send_pair(10'h155, 10'd1022);
    send_pair(10'd1023, 10'd1023);

    base = 0;
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      calm = (n >= 450 && n < 650);
      if (n % 150 == 0) base = $urandom_range(1023 - 47);
      pick = $urandom_range(99);
      if (pick < 45) begin
        a = NODE_W'(base + $urandom_range(47));
        b = NODE_W'(base + $urandom_range(47));
      end else if (pick < 70) begin
        a = NODE_W'($urandom_range(1023));
        b = NODE_W'($urandom_range(1023));
      end else if (pick < 80) begin
        a = NODE_W'($urandom_range(1023));
        b = a;
      end else begin
        a = NODE_W'(base + $urandom_range(47));
        b = NODE_W'($urandom_range(1023));
      end
      send_pair(a, b);
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/wufh_pkg.sv
hdl/wufh_ram.sv
hdl/weighted_union_find_halving_core.sv
bench/set_merge_monitor.sv
bench/weighted_union_find_halving_core_test.sv
